FILE: rtl/stl_pkg.sv
// Shared types, codes and classification functions for the source text lexer.
// No dependencies; every module of the lexer imports this package.
`timescale 1ns / 1ps

package stl_pkg;

  // Offsets and lengths are counted modulo 2**OFFSET_BITS inside the scanner.
  localparam int OFFSET_BITS = 16;
  localparam int OUT_W       = 16;
  localparam int MAX_TOK     = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  // Token classes.
  localparam logic [3:0] K_INT     = 4'd0;
  localparam logic [3:0] K_KEYWORD = 4'd1;
  localparam logic [3:0] K_IDENT   = 4'd2;
  localparam logic [3:0] K_ARROW   = 4'd3;
  localparam logic [3:0] K_ASSIGN  = 4'd4;
  localparam logic [3:0] K_LPAREN  = 4'd5;
  localparam logic [3:0] K_RPAREN  = 4'd6;
  localparam logic [3:0] K_LBRACE  = 4'd7;
  localparam logic [3:0] K_RBRACE  = 4'd8;
  localparam logic [3:0] K_LBRACK  = 4'd9;
  localparam logic [3:0] K_RBRACK  = 4'd10;
  localparam logic [3:0] K_STRING  = 4'd11;
  localparam logic [3:0] K_END     = 4'd12;
  localparam logic [3:0] K_ERROR   = 4'd13;

  // Scanner modes.
  localparam logic [2:0] M_BLANK  = 3'd0;
  localparam logic [2:0] M_WORD   = 3'd1;
  localparam logic [2:0] M_LINE   = 3'd2;
  localparam logic [2:0] M_BLOCK  = 3'd3;
  localparam logic [2:0] M_STRING = 3'd4;
  localparam logic [2:0] M_DEAD   = 3'd5;

  // Keyword tracker codes: 0..8 characters of "function" matched.
  localparam logic [3:0] KW_DONE  = 4'd8;
  localparam logic [3:0] KW_ARROW = 4'd14;
  localparam logic [3:0] KW_NONE  = 4'd15;

  // Characters the scanner tests for.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef logic [OFFSET_BITS-1:0] pos_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] len;
  } token_t;

  // All tokens caused by one input byte, oldest in slot 0.
  typedef struct packed {
    logic [1:0]                cnt;
    token_t [MAX_TOK-1:0]      tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [2:0] mode;
    pos_t       pos;
    pos_t       tbeg;
    logic [3:0] kw;
    logic       dig;
    logic [7:0] tail;
  } lex_state_t;

  typedef struct packed {
    lex_state_t st;
    logic       tv;
    token_t     tok;
  } step_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // Class of a one-character token, or zero when the character is none.
  function automatic logic [3:0] single_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      8'h3D:   k = K_ASSIGN;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h5B:   k = K_LBRACK;
      8'h5D:   k = K_RBRACK;
      default: k = K_INT;
    endcase
    return k;
  endfunction

  // True when a word ends before the bytes n1, n2.
  function automatic logic splits(input logic [7:0] n1, input logic [7:0] n2);
    logic s;
    s = (n1 == CH_NUL) || is_space(n1) || (n1 == CH_QUOTE) || (single_kind(n1) != K_INT);
    s = s || ((n1 == CH_MINUS) && ((n2 == CH_MINUS) || (n2 == CH_BANG) || (n2 == CH_GT)));
    s = s || ((n1 == CH_BANG) && (n2 == CH_MINUS));
    return s;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h66;  // f
      3'd1:    c = 8'h75;  // u
      3'd2:    c = 8'h6E;  // n
      3'd3:    c = 8'h63;  // c
      3'd4:    c = 8'h74;  // t
      3'd5:    c = 8'h69;  // i
      3'd6:    c = 8'h6F;  // o
      default: c = 8'h6E;  // n
    endcase
    return c;
  endfunction

  function automatic token_t mk_tok(input logic [3:0] kind, input pos_t start, input pos_t len);
    token_t t;
    t.kind  = kind;
    t.start = OUT_W'(start);
    t.len   = OUT_W'(len);
    return t;
  endfunction

  // One scanner step on byte c with lookahead n1, n2.
  function automatic step_t consume(input lex_state_t s, input logic [7:0] c,
                                    input logic [7:0] n1, input logic [7:0] n2);
    step_t      r;
    logic [3:0] sk;
    logic [3:0] kwn;
    logic [3:0] wk;
    pos_t       p;
    r     = '0;
    r.st  = s;
    p     = s.pos;
    sk    = single_kind(c);
    case (s.mode)
      M_BLANK: begin
        if (is_space(c)) begin
          r.st.mode = M_BLANK;
        end else if ((c == CH_BANG) && (n1 == CH_MINUS)) begin
          r.tv      = 1'b1;
          r.tok     = mk_tok(K_ERROR, p, pos_t'(2));
          r.st.mode = M_DEAD;
        end else if ((c == CH_MINUS) && (n1 == CH_MINUS)) begin
          r.st.mode = M_LINE;
        end else if ((c == CH_MINUS) && (n1 == CH_BANG)) begin
          r.st.mode = M_BLOCK;
          r.st.tail = CH_NUL;
        end else if (c == CH_QUOTE) begin
          r.st.mode = M_STRING;
          r.st.tbeg = p;
        end else if (sk != K_INT) begin
          r.tv  = 1'b1;
          r.tok = mk_tok(sk, p, pos_t'(1));
        end else begin
          r.st.tbeg = p;
          r.st.dig  = (c >= 8'h30) && (c <= 8'h39);
          if ((c == CH_MINUS) && (n1 == CH_GT)) begin
            kwn = KW_ARROW;
          end else begin
            kwn = (c == kw_char(3'd0)) ? 4'd1 : KW_NONE;
          end
          r.st.kw   = kwn;
          r.st.mode = M_WORD;
          if (splits(n1, n2)) begin
            wk        = r.st.dig ? K_INT : ((kwn == KW_DONE) ? K_KEYWORD : K_IDENT);
            r.tv      = 1'b1;
            r.tok     = mk_tok(wk, p, pos_t'(1));
            r.st.mode = M_BLANK;
          end
        end
      end
      M_WORD: begin
        if (s.kw == KW_ARROW) begin
          r.tv      = 1'b1;
          r.tok     = mk_tok(K_ARROW, s.tbeg, pos_t'(2));
          r.st.mode = M_BLANK;
        end else begin
          kwn = (!s.kw[3] && (c == kw_char(s.kw[2:0]))) ? (s.kw + 4'd1) : KW_NONE;
          r.st.kw = kwn;
          if (splits(n1, n2)) begin
            wk        = s.dig ? K_INT : ((kwn == KW_DONE) ? K_KEYWORD : K_IDENT);
            r.tv      = 1'b1;
            r.tok     = mk_tok(wk, s.tbeg, pos_t'(p + 1'b1 - s.tbeg));
            r.st.mode = M_BLANK;
          end
        end
      end
      M_LINE: begin
        if ((c == CH_LF) || (c == CH_CR)) begin
          r.st.mode = M_BLANK;
        end
      end
      M_BLOCK: begin
        if ((s.tail == CH_BANG) && (c == CH_MINUS)) begin
          r.st.mode = M_BLANK;
        end
        r.st.tail = c;
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          r.tv      = 1'b1;
          r.tok     = mk_tok(K_STRING, pos_t'(s.tbeg + 1'b1), pos_t'(p - s.tbeg - 1'b1));
          r.st.mode = M_BLANK;
        end
      end
      default: begin
        r.st.mode = s.mode;
      end
    endcase
    r.st.pos = pos_t'(p + 1'b1);
    return r;
  endfunction

endpackage

FILE: rtl/stl_front.sv
// Front end of the lexer: two-byte lookahead queue and the scanner state.
// Turns each accepted byte into a bundle of up to three tokens; uses stl_pkg.
`timescale 1ns / 1ps

module stl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_valid,
  input  logic [7:0]       text_byte,
  output stl_pkg::bundle_t bundle,
  output logic             push
);
  import stl_pkg::*;

  lex_state_t st_r, st_nxt;
  logic [7:0] la0_r, la0_nxt;
  logic [7:0] la1_r, la1_nxt;
  logic [1:0] lcnt_r, lcnt_nxt;

  step_t      s1, s2;
  lex_state_t st1;
  logic       tv1, tv2, err_v, is_end, run1;
  logic [7:0] n1;
  token_t     cand [4];
  logic [3:0] cv;
  logic [2:0] idx;
  token_t     err_tok;

  // Two scanner steps in series; the second one only runs at end of text.
  always_comb begin
    is_end = (text_byte == CH_NUL);
    n1     = (lcnt_r == 2'd2) ? la1_r : CH_NUL;
    run1   = (lcnt_r == 2'd2) || (is_end && (lcnt_r == 2'd1));
    s1     = consume(st_r, la0_r, n1, is_end ? CH_NUL : text_byte);
    st1    = run1 ? s1.st : st_r;
    tv1    = run1 && s1.tv;
    s2     = consume(st1, la1_r, CH_NUL, CH_NUL);
    tv2    = is_end && (lcnt_r == 2'd2) && s2.tv;
  end

  // Next state of the scanner and the lookahead queue.
  always_comb begin
    lex_state_t st_end;
    st_end   = (is_end && (lcnt_r == 2'd2)) ? s2.st : st1;
    err_v    = is_end && (st_end.mode == M_STRING);
    err_tok  = mk_tok(K_ERROR, st_end.tbeg, pos_t'(st_end.pos - st_end.tbeg));
    st_nxt   = st_r;
    la0_nxt  = la0_r;
    la1_nxt  = la1_r;
    lcnt_nxt = lcnt_r;
    if (is_end) begin
      st_nxt   = '0;
      la0_nxt  = CH_NUL;
      la1_nxt  = CH_NUL;
      lcnt_nxt = 2'd0;
    end else if (lcnt_r == 2'd2) begin
      st_nxt  = s1.st;
      la0_nxt = la1_r;
      la1_nxt = text_byte;
    end else begin
      if (lcnt_r[0]) begin
        la1_nxt = text_byte;
      end else begin
        la0_nxt = text_byte;
      end
      lcnt_nxt = lcnt_r + 2'd1;
    end
    cand[0] = s1.tok;
    cand[1] = s2.tok;
    cand[2] = err_tok;
    cand[3] = mk_tok(K_END, st_end.pos, '0);
    cv      = {is_end, err_v, tv2, tv1};
  end

  // Pack the valid tokens into the low slots of the bundle.
  always_comb begin
    bundle = '0;
    idx    = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && (idx < 3'(MAX_TOK))) begin
        bundle.tok[idx[1:0]] = cand[i];
        idx = idx + 3'd1;
      end
    end
    bundle.cnt = idx[1:0];
    push       = byte_valid && (idx != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      la0_r  <= CH_NUL;
      la1_r  <= CH_NUL;
      lcnt_r <= 2'd0;
    end else if (byte_valid) begin
      st_r   <= st_nxt;
      la0_r  <= la0_nxt;
      la1_r  <= la1_nxt;
      lcnt_r <= lcnt_nxt;
    end
  end

endmodule

FILE: rtl/stl_queue.sv
// Short bundle queue between the lexer front end and the token serializer.
// Register array with head and tail pointers; uses stl_pkg.
`timescale 1ns / 1ps

module stl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stl_pkg::bundle_t wr_bundle,
  input  logic             pop,
  output stl_pkg::bundle_t head,
  output stl_pkg::q_stat_t stat
);
  import stl_pkg::*;

  bundle_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  // Occupancy flags come straight from the registered count.
  always_comb begin
    stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
    stat.empty = (cnt_r == '0);
    head       = mem_r[rp_r];
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_bundle;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/stl_back.sv
// Back end of the lexer: hands out the tokens of the head bundle one per beat.
// Marks the final token of each bundle; uses stl_pkg.
`timescale 1ns / 1ps

module stl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  stl_pkg::bundle_t head,
  input  stl_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,
  output logic             out_tlast
);
  import stl_pkg::*;

  logic [1:0] sub_r, sub_nxt;
  token_t     tok;
  logic       beat;

  // Select the current token of the head bundle.
  always_comb begin
    out_tvalid = !stat.empty;
    tok        = head.tok[sub_r];
    out_tlast  = (sub_r == (head.cnt - 2'd1));
    out_tdata  = {4'd0, tok.len, tok.start, tok.kind};
    beat       = out_tvalid && out_tready;
    pop        = beat && out_tlast;
    sub_nxt    = sub_r;
    if (beat) begin
      sub_nxt = out_tlast ? 2'd0 : (sub_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 2'd0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

FILE: rtl/source_text_lexer_core.sv
// Top level of the source text lexer: front end, bundle queue and serializer.
// Depends on stl_pkg, stl_front, stl_queue and stl_back.
//
//   port group | dir | tdata / tuser / tlast contents
//   in_        | in  | tdata[7:0] text_byte
//   out_       | out | tdata[3:0] token_kind, [19:4] start_offset,
//              |     | [35:20] token_length; tlast last_of_run
//
// One byte is taken per cycle while the queue is not full; its tokens enter a
// four-entry queue the same edge. Tokens leave one per beat, so a byte that
// causes up to three tokens (end of text) holds the output for that many beats;
// the queue depth sets how long the input keeps flowing while the output stalls.
// Tokens pass the registered queue before the output and lag the text by two
// bytes of lookahead. Synchronous active-low reset clears all but the queue data.
`timescale 1ns / 1ps

module source_text_lexer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] token_kind, [19:4] start_offset,
                                  // [35:20] token_length, [39:36] zero
  output logic        out_tlast   // last_of_run
);
  import stl_pkg::*;

  bundle_t bundle, head;
  q_stat_t stat;
  logic    push, pop, in_beat;

  assign in_tready = !stat.full;
  assign in_beat   = in_tvalid && in_tready;

  stl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_beat),
    .text_byte  (in_tdata),
    .bundle     (bundle),
    .push       (push)
  );

  stl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_bundle (bundle),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  stl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  // A queued bundle always carries at least one token.
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.empty |-> (head.cnt != 2'd0))
    else $error("empty bundle at queue head");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("bundle pushed into full queue");

  // End of text always yields a bundle closed by the end token.
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_tdata == CH_NUL)) |->
      (push && (bundle.tok[bundle.cnt - 2'd1].kind == K_END)))
    else $error("end of text without end token");
`endif

endmodule

FILE: sim/source_text_lexer_core_tb.sv
// Self-checking testbench for source_text_lexer_core: streams text bytes in and checks
// every token beat against a scanner model kept inside the bench.
// Depends on stl_pkg for token classes, scanner modes and character codes.
`timescale 1ns / 1ps

module source_text_lexer_core_tb;
  import stl_pkg::*;

  // Token as it should leave the block.
  typedef struct {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        run_end;
  } lex_tok_t;

  localparam logic [63:0] KEYWORD_TEXT = "function";

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  // Stimulus and expectations.
  logic [7:0] text_bytes[$];
  lex_tok_t   pending_tokens[$];
  lex_tok_t   step_toks[$];
  int         sent_count = 0;
  int         got_count = 0;
  int         mismatches = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;

  // Scanner state of the model.
  logic [2:0] sc_mode;
  pos_t       sc_pos;
  pos_t       sc_tbeg;
  logic [7:0] la_bytes[2];
  int         la_count;
  logic [3:0] sc_kw;
  logic       sc_dig;
  logic [7:0] sc_tail;

  source_text_lexer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------

  task automatic clear_scanner();
    sc_mode     = M_BLANK;
    sc_pos      = '0;
    sc_tbeg     = '0;
    la_bytes[0] = CH_NUL;
    la_bytes[1] = CH_NUL;
    la_count    = 0;
    sc_kw       = 4'd0;
    sc_dig      = 1'b0;
    sc_tail     = CH_NUL;
  endtask

  function automatic logic blank_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // Class of a one-character token; K_INT means the character is not one.
  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    case (c)
      "=":     return K_ASSIGN;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      "[":     return K_LBRACK;
      "]":     return K_RBRACK;
      default: return K_INT;
    endcase
  endfunction

  // A word ends when the next two bytes begin something else.
  function automatic logic word_ends(input logic [7:0] n1, input logic [7:0] n2);
    if (n1 == CH_NUL || blank_char(n1) || n1 == CH_QUOTE || punct_kind(n1) != K_INT)
      return 1'b1;
    if (n1 == CH_MINUS && (n2 == CH_MINUS || n2 == CH_BANG || n2 == CH_GT))
      return 1'b1;
    return (n1 == CH_BANG) && (n2 == CH_MINUS);
  endfunction

  function automatic logic [7:0] keyword_char(input logic [3:0] idx);
    int hi;
    hi = 63 - 8 * idx;
    return KEYWORD_TEXT[hi -: 8];
  endfunction

  task automatic emit_token(input logic [3:0] kind, input pos_t start, input pos_t len);
    lex_tok_t t;
    t.kind    = kind;
    t.start   = start;
    t.len     = len;
    t.run_end = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic close_word(input pos_t p);
    pos_t len;
    len     = p + 16'd1 - sc_tbeg;
    sc_mode = M_BLANK;
    if (sc_dig)
      emit_token(K_INT, sc_tbeg, len);
    else if (sc_kw == KW_DONE)
      emit_token(K_KEYWORD, sc_tbeg, len);
    else
      emit_token(K_IDENT, sc_tbeg, len);
  endtask

  // One scanner step on byte c, seeing the two bytes after it.
  task automatic scan_char(input logic [7:0] c, input logic [7:0] n1, input logic [7:0] n2);
    pos_t p;
    pos_t len;
    p = sc_pos;
    case (sc_mode)
      M_BLANK: begin
        if (!blank_char(c)) begin
          if (c == CH_BANG && n1 == CH_MINUS) begin
            emit_token(K_ERROR, p, 16'd2);
            sc_mode = M_DEAD;
          end else if (c == CH_MINUS && n1 == CH_MINUS) begin
            sc_mode = M_LINE;
          end else if (c == CH_MINUS && n1 == CH_BANG) begin
            sc_mode = M_BLOCK;
            sc_tail = CH_NUL;
          end else if (c == CH_QUOTE) begin
            sc_mode = M_STRING;
            sc_tbeg = p;
          end else if (punct_kind(c) != K_INT) begin
            emit_token(punct_kind(c), p, 16'd1);
          end else begin
            sc_tbeg = p;
            sc_dig  = (c >= "0") && (c <= "9");
            if (c == CH_MINUS && n1 == CH_GT)
              sc_kw = KW_ARROW;
            else
              sc_kw = (c == keyword_char(4'd0)) ? 4'd1 : KW_NONE;
            sc_mode = M_WORD;
            if (word_ends(n1, n2))
              close_word(p);
          end
        end
      end
      M_WORD: begin
        if (sc_kw == KW_ARROW) begin
          emit_token(K_ARROW, sc_tbeg, 16'd2);
          sc_mode = M_BLANK;
        end else begin
          if (sc_kw < KW_DONE && c == keyword_char(sc_kw))
            sc_kw = sc_kw + 4'd1;
          else
            sc_kw = KW_NONE;
          if (word_ends(n1, n2))
            close_word(p);
        end
      end
      M_LINE: begin
        if (c == CH_LF || c == CH_CR)
          sc_mode = M_BLANK;
      end
      M_BLOCK: begin
        if (sc_tail == CH_BANG && c == CH_MINUS)
          sc_mode = M_BLANK;
        sc_tail = c;
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          len = p - sc_tbeg - 16'd1;
          emit_token(K_STRING, sc_tbeg + 16'd1, len);
          sc_mode = M_BLANK;
        end
      end
      default: ;
    endcase
    sc_pos = p + 16'd1;
  endtask

  // Works out the tokens one accepted byte causes and queues them.
  task automatic tokenize_byte(input logic [7:0] ch);
    lex_tok_t t;
    if (ch != CH_NUL) begin
      if (la_count >= 2) begin
        scan_char(la_bytes[0], la_bytes[1], ch);
        la_bytes[0] = la_bytes[1];
        la_bytes[1] = ch;
      end else begin
        la_bytes[la_count] = ch;
        la_count++;
      end
    end else begin
      // End of text drains the lookahead, then everything starts over.
      if (la_count >= 2) begin
        scan_char(la_bytes[0], la_bytes[1], CH_NUL);
        scan_char(la_bytes[1], CH_NUL, CH_NUL);
      end else if (la_count == 1) begin
        scan_char(la_bytes[0], CH_NUL, CH_NUL);
      end
      if (sc_mode == M_STRING)
        emit_token(K_ERROR, sc_tbeg, sc_pos - sc_tbeg);
      emit_token(K_END, sc_pos, 16'd0);
      clear_scanner();
    end
    for (int i = 0; i < step_toks.size(); i++) begin
      t = step_toks[i];
      t.run_end = (i == step_toks.size() - 1);
      pending_tokens.push_back(t);
    end
    step_toks.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_char(input logic [7:0] c);
    text_bytes.push_back(c);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      text_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 3))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("0" + $urandom_range(0, 9));
      2:       return 8'("A" + $urandom_range(0, 25));
      default: return "_";
    endcase
  endfunction

  // Any nonzero byte, steered away from the one that would end the context.
  function automatic logic [7:0] body_char(input logic [7:0] avoid1, input logic [7:0] avoid2);
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == avoid1 || c == avoid2)
      c = "x";
    return c;
  endfunction

  // One random lexical element.
  task automatic add_fragment();
    int         n;
    string      s;
    n      = $urandom_range(0, 6);
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        add_char(8'("a" + $urandom_range(0, 25)));
        repeat (n) add_char(word_char());
      end
      3: begin
        add_char(8'("0" + $urandom_range(0, 9)));
        repeat (n) add_char(word_char());
      end
      4: begin
        s = "function";
        case ($urandom_range(0, 2))
          0: add_text(s);
          1: begin
            add_text(s);
            add_char(word_char());
          end
          default: add_text(s.substr(0, $urandom_range(0, 6)));
        endcase
      end
      5: add_text("->");
      6, 7: begin
        s = "(){}[]=";
        add_char(s[$urandom_range(0, 6)]);
      end
      8, 9: begin
        add_char(CH_QUOTE);
        repeat (n) add_char(body_char(CH_QUOTE, CH_QUOTE));
        add_char(CH_QUOTE);
      end
      10: begin
        add_text("--");
        repeat (n) add_char(body_char(CH_LF, CH_CR));
        add_char($urandom_range(0, 1) ? CH_LF : CH_CR);
      end
      11: begin
        add_text("-!");
        repeat (n) add_char(body_char(CH_NUL, CH_NUL));
        add_text("!-");
      end
      12: begin
        s = "-!>=\"";
        add_char(s[$urandom_range(0, 4)]);
      end
      13: begin
        repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(1, 255)));
      end
      default: begin
        s = " \t\n\r";
        add_char(s[$urandom_range(0, 3)]);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers queued bytes, idling at random outside a quiet window
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : driver
    logic quiet;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      clear_scanner();
    end else begin
      quiet = (sent_count >= 150) && (sent_count < 260);
      if (in_tvalid && in_tready) begin
        tokenize_byte(in_tdata);
        sent_count <= sent_count + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (text_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 19)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= text_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, one long hold-off to back the block up
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && got_count >= 40) begin
      out_tready <= 1'b0;
      hold_left  <= 120;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ((got_count >= 100) && (got_count < 180)) || ($urandom_range(0, 99) >= 19);
    end
  end

  // Every token beat is compared with the oldest expected token.
  always @(posedge clk) begin : monitor
    lex_tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got_count <= got_count + 1;
      if (pending_tokens.size() == 0) begin
        $error("unexpected token beat: kind %0d start %0d len %0d",
               out_tdata[3:0], out_tdata[19:4], out_tdata[35:20]);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        if (out_tdata[3:0] != want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, out_tdata[3:0]);
          mismatches++;
        end
        if (out_tdata[19:4] != want.start) begin
          $error("start_offset: expected %0d, got %0d", want.start, out_tdata[19:4]);
          mismatches++;
        end
        if (out_tdata[35:20] != want.len) begin
          $error("token_length: expected %0d, got %0d", want.len, out_tdata[35:20]);
          mismatches++;
        end
        if (out_tlast != want.run_end) begin
          $error("last_of_run: expected %0d, got %0d", want.run_end, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin : sequencer
    int nfrag;
    int waited;

    // Keyword, integer cut by an arrow, identifier, assign and an empty string.
    add_text("function 9->x=\"\"");
    add_char(CH_NUL);
    // Braces and square brackets, a comment that closes itself, then a stray close mark
    // after which the rest of the text is ignored.
    add_text("{}[]-!-!-z");
    add_char(CH_NUL);
    // Unterminated string holding the top byte value.
    add_char(CH_QUOTE);
    add_char(8'hFF);
    add_char(CH_NUL);
    // Unterminated block comment, then an empty text.
    add_text("-!");
    add_char(CH_NUL);
    add_char(CH_NUL);

    // Random texts, mostly well formed, some ending in a broken tail.
    while (text_bytes.size() < 320) begin
      nfrag = $urandom_range(2, 12);
      repeat (nfrag) begin
        add_fragment();
        if ($urandom_range(0, 2) != 0)
          add_char(CH_SPACE);
      end
      case ($urandom_range(0, 9))
        0: begin
          add_text("!-");
          repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(1, 255)));
        end
        1: begin
          add_char(CH_QUOTE);
          repeat ($urandom_range(0, 3)) add_char(word_char());
        end
        default: ;
      endcase
      add_char(CH_NUL);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (text_bytes.size() != 0 || in_tvalid)
      @(posedge clk);
    waited = 0;
    while (pending_tokens.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (pending_tokens.size() != 0)
        $error("%0d expected tokens never arrived", pending_tokens.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #(4_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
